/* hdl/mcs_pkg.sv */
// Shared types, constants and helpers for the mux channel scan sampler.
package mcs_pkg;

    localparam int CHAN_COUNT = 16;
    localparam int CHAN_W     = 4;
    localparam int ADC_W      = 12;
    localparam int VALUE_W    = 16;
    localparam int SETTLE_W   = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // item modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ANALOG    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_USE_ADC   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE    = 3'd4;

    localparam logic [ADC_W-1:0]    THRESHOLD_RST = 12'd1000;
    localparam logic [SETTLE_W-1:0] SETTLE_RST    = 8'd10;

    typedef struct packed {
        logic [CHAN_COUNT-1:0] enable_mask;
        logic [CHAN_COUNT-1:0] analog_mask;
        logic                  use_adc;
        logic [ADC_W-1:0]      threshold;
        logic [SETTLE_W-1:0]   settle_time;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0]  channel_address;
        logic               sample_request;
        logic [VALUE_W-1:0] read_value;
    } t_result;

    // scan position to mux address: reflected binary Gray code
    function automatic logic [CHAN_W-1:0] gray_of(input logic [CHAN_W-1:0] step);
        return step ^ (step >> 1);
    endfunction

endpackage

/* hdl/mcs_cfg_regs.sv */
// Configuration register file of the scan sampler.
module mcs_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mcs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [mcs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mcs_pkg::t_cfg                  o_cfg
);
    import mcs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_mask <= '0;
            r_cfg.analog_mask <= '0;
            r_cfg.use_adc     <= 1'b0;
            r_cfg.threshold   <= THRESHOLD_RST;
            r_cfg.settle_time <= SETTLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ENABLE:    r_cfg.enable_mask <= i_cfg_data[CHAN_COUNT-1:0];
                REG_ANALOG:    r_cfg.analog_mask <= i_cfg_data[CHAN_COUNT-1:0];
                REG_USE_ADC:   r_cfg.use_adc     <= i_cfg_data[0];
                REG_THRESHOLD: r_cfg.threshold   <= i_cfg_data[ADC_W-1:0];
                REG_SETTLE:    r_cfg.settle_time <= i_cfg_data[SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/mcs_scan_core.sv */
// Scan state, sample stores and per-item result logic.
module mcs_scan_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  mcs_pkg::t_cfg              i_cfg,
    input  logic [1:0]                 i_mode,
    input  logic [mcs_pkg::ADC_W-1:0]  i_adc_sample,
    input  logic                       i_pin_level,
    input  logic [mcs_pkg::CHAN_W-1:0] i_query_channel,
    output mcs_pkg::t_result           o_result
);
    import mcs_pkg::*;

    localparam int STORE_W = (SAMPLE_BITS < ADC_W) ? SAMPLE_BITS : ADC_W;
    localparam logic [ADC_W-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((1 << SAMPLE_BITS) - 1);

    logic [CHAN_W-1:0]     r_gray_step, n_gray_step;
    logic [SETTLE_W-1:0]   r_settle, n_settle;
    logic [CHAN_COUNT-1:0] r_digital, n_digital;
    logic [STORE_W-1:0]    r_analog [CHAN_COUNT];

    logic [CHAN_W-1:0]  cur_ch;
    logic [ADC_W-1:0]   adc_m;
    logic               ch_en;
    logic               store_analog;
    logic [VALUE_W-1:0] rv;

    assign cur_ch       = gray_of(r_gray_step);
    assign adc_m        = i_adc_sample & SAMPLE_MASK;
    assign ch_en        = i_cfg.enable_mask[cur_ch];
    assign store_analog = (i_mode == MODE_SAMPLE) && ch_en && i_cfg.use_adc &&
                          i_cfg.analog_mask[cur_ch];

    always_comb begin
        n_gray_step = r_gray_step;
        n_settle    = r_settle;
        n_digital   = r_digital;
        rv          = '0;
        case (i_mode)
            MODE_TICK: begin
                if (r_settle < i_cfg.settle_time)
                    n_settle = r_settle + 1'b1;
            end
            MODE_SAMPLE: begin
                if (ch_en && !store_analog) begin
                    n_digital[cur_ch] = i_cfg.use_adc ? (adc_m >= i_cfg.threshold)
                                                      : i_pin_level;
                end
                n_gray_step = r_gray_step + 1'b1;
                n_settle    = '0;
            end
            MODE_READ: begin
                if (!i_cfg.enable_mask[i_query_channel])
                    rv = '0;
                else if (!i_cfg.analog_mask[i_query_channel])
                    rv = VALUE_W'(r_digital[i_query_channel]) << i_query_channel;
                else
                    rv = VALUE_W'(r_analog[i_query_channel]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_step <= '0;
            r_settle    <= '0;
            r_digital   <= '0;
            for (int i = 0; i < CHAN_COUNT; i++)
                r_analog[i] <= '0;
        end else if (i_take) begin
            r_gray_step <= n_gray_step;
            r_settle    <= n_settle;
            r_digital   <= n_digital;
            if (store_analog)
                r_analog[cur_ch] <= adc_m[STORE_W-1:0];
        end
    end

    assign o_result.channel_address = gray_of(n_gray_step);
    assign o_result.sample_request  = (n_settle >= i_cfg.settle_time);
    assign o_result.read_value      = rv;

endmodule

/* hdl/mcs_out_reg.sv */
// Result register on the output channel.
module mcs_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  mcs_pkg::t_result i_result,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic             o_free,
    output mcs_pkg::t_result o_result
);
    import mcs_pkg::*;

    logic    r_valid;
    t_result r_result;

    // register can load when empty or when its content transfers this cycle
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= 1'b0;
        else if (o_free)
            r_valid <= i_take;
    end

    always_ff @(posedge i_clk) begin
        if (i_take)
            r_result <= i_result;
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

/* hdl/mux_channel_scan_sampler.sv */
// Top level: Gray-order channel scanner for a 16-way analog multiplexer.
// The result is registered; it is valid in the cycle after the input transfer.
// Throughput: one item per cycle; the result register refills in the cycle it drains.
// Input stalls only while a result is held under output stall.
// Synchronous active-low reset sets configuration to its defaults and clears scan state and both stores.
module mux_channel_scan_sampler #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mcs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [mcs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_mode,
    input  logic [mcs_pkg::ADC_W-1:0]      i_adc_sample,
    input  logic                           i_pin_level,
    input  logic [mcs_pkg::CHAN_W-1:0]     i_query_channel,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [mcs_pkg::CHAN_W-1:0]     o_channel_address,
    output logic                           o_sample_request,
    output logic [mcs_pkg::VALUE_W-1:0]    o_read_value
);
    import mcs_pkg::*;

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    out_free;
    logic    take;

    assign o_in_stall = !out_free;
    assign take       = i_in_valid && out_free;

    mcs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mcs_scan_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_cfg           (cfg),
        .i_mode          (i_mode),
        .i_adc_sample    (i_adc_sample),
        .i_pin_level     (i_pin_level),
        .i_query_channel (i_query_channel),
        .o_result        (core_result)
    );

    mcs_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_result    (core_result),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_free      (out_free),
        .o_result    (out_result)
    );

    assign o_channel_address = out_result.channel_address;
    assign o_sample_request  = out_result.sample_request;
    assign o_read_value      = out_result.read_value;

endmodule

/* hdl/mcs_checker.sv */
// Port-level checks for the scan sampler, bound to the top level.
module mcs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic [1:0]                     i_mode,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [mcs_pkg::CHAN_W-1:0]     o_channel_address,
    input logic                           o_sample_request,
    input logic [mcs_pkg::VALUE_W-1:0]    o_read_value
);
    import mcs_pkg::*;

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // every accepted item shows a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_out_valid)
        else $error("accepted item produced no result");

    // only read queries carry a nonzero read value
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_mode != MODE_READ)) |=> (o_read_value == '0))
        else $error("non-read item returned a read value");

    // held result stays put under stall
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_channel_address) && $stable(o_sample_request)
             && $stable(o_read_value)))
        else $error("stalled result changed");

endmodule

bind mux_channel_scan_sampler mcs_checker u_mcs_checker (.*);
